[rtl/gpe_pkg.sv]
`timescale 1ns / 1ps

package gpe_pkg;

    // Field widths
    localparam int STATUS_W  = 2;
    localparam int PACKET_W  = 32;
    localparam int BUTTONS_W = 16;
    localparam int AXIS_W    = 16;
    localparam int TRIG_W    = 8;
    localparam int INDEX_W   = 4;
    localparam int CODE_W    = 2;
    localparam int RADIUS_W  = 16;
    localparam int SKIP_W    = 8;
    localparam int SQ_W      = 32;

    // Input tdata layout, lowest bit first
    localparam int PACKET_LO  = 0;
    localparam int BUTTONS_LO = PACKET_LO + PACKET_W;
    localparam int LX_LO      = BUTTONS_LO + BUTTONS_W;
    localparam int LY_LO      = LX_LO + AXIS_W;
    localparam int RX_LO      = LY_LO + AXIS_W;
    localparam int RY_LO      = RX_LO + AXIS_W;
    localparam int LT_LO      = RY_LO + AXIS_W;
    localparam int RT_LO      = LT_LO + TRIG_W;
    localparam int S_DATA_W   = RT_LO + TRIG_W;

    // Output tdata layout: index, pressed, code, buttons, one pad bit
    localparam int M_FIELDS_W = INDEX_W + 1 + CODE_W + BUTTONS_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP      = 2'd2;
    localparam logic [RADIUS_W-1:0]    DEADZONE_RESET = 16'd3200;
    localparam logic [TRIG_W-1:0]      TRIGGER_RESET  = 8'd30;
    localparam logic [SKIP_W-1:0]      SKIP_RESET     = 8'd60;

    localparam int BUTTON_COUNT_DEFAULT = 16;

    // Poll status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_DEVICE  = 2'd1;

    // Poll result codes
    localparam logic [CODE_W-1:0] CODE_IDLE     = 2'd0;
    localparam logic [CODE_W-1:0] CODE_ACTIVITY = 2'd1;
    localparam logic [CODE_W-1:0] CODE_SKIPPED  = 2'd2;
    localparam logic [CODE_W-1:0] CODE_ERROR    = 2'd3;

    // Result of the motion unit
    typedef struct packed {
        logic done;
        logic past;
    } motion_status_t;

endpackage

[rtl/gpe_motion_unit.sv]
`timescale 1ns / 1ps

// Radial deadzone test on both sticks with one shared squarer:
// r*r, then lx, ly, rx, ry squared, one square per cycle.
module gpe_motion_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [gpe_pkg::AXIS_W-1:0]   left_x,
    input  logic signed [gpe_pkg::AXIS_W-1:0]   left_y,
    input  logic signed [gpe_pkg::AXIS_W-1:0]   right_x,
    input  logic signed [gpe_pkg::AXIS_W-1:0]   right_y,
    input  logic        [gpe_pkg::RADIUS_W-1:0] radius,
    output gpe_pkg::motion_status_t             status
);

    localparam int OP_W = gpe_pkg::AXIS_W + 1;
    localparam int SQ_W = gpe_pkg::SQ_W;

    localparam logic [2:0] STEP_R    = 3'd0;
    localparam logic [2:0] STEP_LX   = 3'd1;
    localparam logic [2:0] STEP_LY   = 3'd2;
    localparam logic [2:0] STEP_RX   = 3'd3;
    localparam logic [2:0] STEP_RY   = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd5;

    logic                           busy_reg, busy_next;
    logic [2:0]                     step_reg, step_next;
    logic signed [gpe_pkg::AXIS_W-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [gpe_pkg::RADIUS_W-1:0]   r_reg;
    logic [SQ_W-1:0]                prod_reg;
    logic [SQ_W-1:0]                rsq_reg;
    logic [SQ_W-1:0]                acc_reg;
    logic                           past_l_reg;

    logic signed [OP_W-1:0]         op;
    logic signed [2*OP_W-1:0]       sq;
    logic [SQ_W:0]                  mag_sum;
    logic                           sum_gt;

    // Select the operand for this step
    always_comb begin
        unique case (step_reg)
            STEP_R:  op = $signed({1'b0, r_reg});
            STEP_LX: op = OP_W'(lx_reg);
            STEP_LY: op = OP_W'(ly_reg);
            STEP_RX: op = OP_W'(rx_reg);
            STEP_RY: op = OP_W'(ry_reg);
            default: op = '0;
        endcase
    end

    assign sq      = op * op;
    assign mag_sum = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign sum_gt  = mag_sum > {1'b0, rsq_reg};

    // Advance the step counter
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_R;
        end else if (busy_reg) begin
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= STEP_R;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Latch operands, square, accumulate per stick
    always_ff @(posedge aclk) begin
        if (start) begin
            lx_reg <= left_x;
            ly_reg <= left_y;
            rx_reg <= right_x;
            ry_reg <= right_y;
            r_reg  <= radius;
        end
        if (busy_reg) begin
            prod_reg <= sq[SQ_W-1:0];
            unique case (step_reg)
                STEP_LX: rsq_reg    <= prod_reg;
                STEP_LY: acc_reg    <= prod_reg;
                STEP_RX: past_l_reg <= sum_gt;
                STEP_RY: acc_reg    <= prod_reg;
                default: ;
            endcase
        end
    end

    assign status.done = busy_reg && (step_reg == STEP_LAST);
    assign status.past = past_l_reg | sum_gt;

endmodule

[rtl/gamepad_poll_event_detector_unit.sv]
`timescale 1ns / 1ps

// Gamepad poll event detector. Each poll transfer on s_ yields one or more
// result transfers on m_, the last marked by m_tlast. A poll that changes
// buttons under a new packet number gives one event per changed button
// among the first min(BUTTON_COUNT, 16), lowest index first, then a final
// code item; the sequencer visits one button index per cycle, waiting
// while an event cannot load because of an m_tready stall. A new packet
// without a button change runs the stick test on one shared squarer,
// five squares, before the final code item. Skipped, disconnected, error
// and repeated-packet polls give only the final code item. s_tready is
// high only while the sequencer is idle. Configuration writes are taken
// at any time on the cfg_ channel; index 3 is ignored.
module gamepad_poll_event_detector_unit #(
    parameter int BUTTON_COUNT = gpe_pkg::BUTTON_COUNT_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // poll
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // packet_number, button_bits, left_stick_x, left_stick_y,
    // right_stick_x, right_stick_y, left_trigger, right_trigger
    input  logic [gpe_pkg::S_DATA_W-1:0]        s_tdata,
    // poll_status
    input  logic [gpe_pkg::STATUS_W-1:0]        s_tuser,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // button_index, pressed, poll_code, buttons_now, one zero pad bit
    output logic [gpe_pkg::M_DATA_W-1:0]        m_tdata,
    // is_button_event
    output logic                                m_tuser,
    output logic                                m_tlast,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SCAN_N = (BUTTON_COUNT < gpe_pkg::BUTTONS_W) ?
                            BUTTON_COUNT : gpe_pkg::BUTTONS_W;
    localparam logic [gpe_pkg::INDEX_W-1:0] SCAN_LAST = gpe_pkg::INDEX_W'(SCAN_N - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_MOTION = 4'b0100,
        ST_FINAL  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [gpe_pkg::RADIUS_W-1:0] radius_reg;
    logic [gpe_pkg::TRIG_W-1:0]   trig_thr_reg;
    logic [gpe_pkg::SKIP_W-1:0]   skip_load_reg;

    // Poll state
    logic [gpe_pkg::PACKET_W-1:0]  last_packet_reg, last_packet_next;
    logic [gpe_pkg::BUTTONS_W-1:0] last_buttons_reg, last_buttons_next;
    logic [gpe_pkg::BUTTONS_W-1:0] held_reg, held_next;
    logic [gpe_pkg::SKIP_W-1:0]    skip_reg, skip_next;
    logic                          moving_reg, moving_next;

    // Per-poll working registers
    logic [gpe_pkg::BUTTONS_W-1:0] changed_reg, changed_next;
    logic [gpe_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [gpe_pkg::INDEX_W-1:0]   idx_reg, idx_next;
    logic                          trig_hit_reg, trig_hit_next;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    logic [gpe_pkg::INDEX_W-1:0]   o_index_reg, o_index_next;
    logic                          o_pressed_reg, o_pressed_next;
    logic [gpe_pkg::CODE_W-1:0]    o_code_reg, o_code_next;
    logic [gpe_pkg::BUTTONS_W-1:0] o_buttons_reg, o_buttons_next;
    logic                          o_event_reg, o_event_next;
    logic                          o_last_reg, o_last_next;

    // Poll fields
    logic [gpe_pkg::PACKET_W-1:0]      in_packet;
    logic [gpe_pkg::BUTTONS_W-1:0]     in_buttons;
    logic [gpe_pkg::BUTTONS_W-1:0]     in_changed;
    logic [gpe_pkg::TRIG_W-1:0]        in_lt, in_rt;
    logic                              s_accept;
    logic                              can_load;
    logic                              motion_start;
    gpe_pkg::motion_status_t           motion_status;

    assign in_packet  = s_tdata[gpe_pkg::PACKET_LO  +: gpe_pkg::PACKET_W];
    assign in_buttons = s_tdata[gpe_pkg::BUTTONS_LO +: gpe_pkg::BUTTONS_W];
    assign in_lt      = s_tdata[gpe_pkg::LT_LO +: gpe_pkg::TRIG_W];
    assign in_rt      = s_tdata[gpe_pkg::RT_LO +: gpe_pkg::TRIG_W];
    assign in_changed = last_buttons_reg ^ in_buttons;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign can_load  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    gpe_motion_unit u_motion (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (motion_start),
        .left_x  ($signed(s_tdata[gpe_pkg::LX_LO +: gpe_pkg::AXIS_W])),
        .left_y  ($signed(s_tdata[gpe_pkg::LY_LO +: gpe_pkg::AXIS_W])),
        .right_x ($signed(s_tdata[gpe_pkg::RX_LO +: gpe_pkg::AXIS_W])),
        .right_y ($signed(s_tdata[gpe_pkg::RY_LO +: gpe_pkg::AXIS_W])),
        .radius  (radius_reg),
        .status  (motion_status)
    );

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= gpe_pkg::DEADZONE_RESET;
            trig_thr_reg  <= gpe_pkg::TRIGGER_RESET;
            skip_load_reg <= gpe_pkg::SKIP_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gpe_pkg::CFG_DEADZONE: radius_reg    <= cfg_data;
                gpe_pkg::CFG_TRIGGER:  trig_thr_reg  <= cfg_data[gpe_pkg::TRIG_W-1:0];
                gpe_pkg::CFG_SKIP:     skip_load_reg <= cfg_data[gpe_pkg::SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        last_packet_next  = last_packet_reg;
        last_buttons_next = last_buttons_reg;
        held_next         = held_reg;
        skip_next         = skip_reg;
        moving_next       = moving_reg;
        changed_next      = changed_reg;
        code_next         = code_reg;
        idx_next          = idx_reg;
        trig_hit_next     = trig_hit_reg;
        motion_start      = 1'b0;

        m_valid_next   = m_valid_reg && !m_tready;
        o_index_next   = o_index_reg;
        o_pressed_next = o_pressed_reg;
        o_code_next    = o_code_reg;
        o_buttons_next = o_buttons_reg;
        o_event_next   = o_event_reg;
        o_last_next    = o_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next      = '0;
                    changed_next  = in_changed;
                    trig_hit_next = (in_lt > trig_thr_reg) || (in_rt > trig_thr_reg);
                    state_next    = ST_FINAL;
                    priority if (skip_reg != '0) begin
                        skip_next = skip_reg - 1'b1;
                        code_next = gpe_pkg::CODE_SKIPPED;
                    end else if (s_tuser == gpe_pkg::STATUS_NO_DEVICE) begin
                        skip_next = skip_load_reg;
                        code_next = gpe_pkg::CODE_SKIPPED;
                    end else if (s_tuser != gpe_pkg::STATUS_OK) begin
                        code_next = gpe_pkg::CODE_ERROR;
                    end else if (in_packet == last_packet_reg) begin
                        held_next = in_buttons;
                        code_next = moving_reg ? gpe_pkg::CODE_ACTIVITY
                                               : gpe_pkg::CODE_IDLE;
                    end else begin
                        held_next         = in_buttons;
                        last_packet_next  = in_packet;
                        last_buttons_next = in_buttons;
                        code_next         = gpe_pkg::CODE_ACTIVITY;
                        if (in_changed != '0) begin
                            state_next = ST_SCAN;
                        end else begin
                            motion_start = 1'b1;
                            state_next   = ST_MOTION;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Visit one button a cycle; wait when an event cannot load
                if (!changed_reg[idx_reg] || can_load) begin
                    if (changed_reg[idx_reg]) begin
                        m_valid_next   = 1'b1;
                        o_index_next   = idx_reg;
                        o_pressed_next = held_reg[idx_reg];
                        o_code_next    = gpe_pkg::CODE_ACTIVITY;
                        o_buttons_next = held_reg;
                        o_event_next   = 1'b1;
                        o_last_next    = 1'b0;
                    end
                    if (idx_reg == SCAN_LAST) begin
                        state_next = ST_FINAL;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_MOTION: begin
                if (motion_status.done) begin
                    moving_next = motion_status.past | trig_hit_reg;
                    state_next  = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (can_load) begin
                    m_valid_next   = 1'b1;
                    o_index_next   = '0;
                    o_pressed_next = 1'b0;
                    o_code_next    = code_reg;
                    o_buttons_next = held_reg;
                    o_event_next   = 1'b0;
                    o_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and poll state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            last_packet_reg  <= '0;
            last_buttons_reg <= '0;
            held_reg         <= '0;
            skip_reg         <= '0;
            moving_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            last_packet_reg  <= last_packet_next;
            last_buttons_reg <= last_buttons_next;
            held_reg         <= held_next;
            skip_reg         <= skip_next;
            moving_reg       <= moving_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Working and output payload
    always_ff @(posedge aclk) begin
        changed_reg   <= changed_next;
        code_reg      <= code_next;
        idx_reg       <= idx_next;
        trig_hit_reg  <= trig_hit_next;
        o_index_reg   <= o_index_next;
        o_pressed_reg <= o_pressed_next;
        o_code_reg    <= o_code_next;
        o_buttons_reg <= o_buttons_next;
        o_event_reg   <= o_event_next;
        o_last_reg    <= o_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_event_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = gpe_pkg::M_DATA_W'({o_buttons_reg, o_code_reg,
                                          o_pressed_reg, o_index_reg});

endmodule
